// File: hdl/klps_pkg.sv
`timescale 1ns / 1ps

package klps_pkg;

  localparam int unsigned KeyW  = 4;
  localparam int unsigned LedW  = 8;
  localparam int unsigned TickW = 16;
  localparam int unsigned StepW = 6;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [KeyW-1:0] NO_KEY           = 4'hF;
  localparam logic [KeyW-1:0] MODE_CHASE_LONG  = 4'hE;
  localparam logic [KeyW-1:0] MODE_CHASE_SHORT = 4'hD;
  localparam logic [KeyW-1:0] MODE_BLINK_AA55  = 4'hB;
  localparam logic [KeyW-1:0] MODE_BLINK_0FF0  = 4'h7;

  localparam logic [LedW-1:0] LED_AA  = 8'hAA;
  localparam logic [LedW-1:0] LED_55  = 8'h55;
  localparam logic [LedW-1:0] LED_0F  = 8'h0F;
  localparam logic [LedW-1:0] LED_F0  = 8'hF0;
  localparam logic [LedW-1:0] LED_TOP = 8'h80;

  localparam logic [StepW-1:0] FILL_LAST       = 6'd7;
  localparam logic [StepW-1:0] SHIFT_LAST      = 6'd15;
  localparam logic [StepW-1:0] BACK_FILL_LAST  = 6'd23;
  localparam logic [StepW-1:0] BACK_SHIFT_LAST = 6'd31;

  localparam logic [TickW-1:0] STEP_PERIOD_RST  = 16'd5000;
  localparam logic [TickW-1:0] BLINK_FIRST_RST  = 16'd10000;
  localparam logic [TickW-1:0] BLINK_SECOND_RST = 16'd20000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_STEP_PERIOD  = 2'd0,
    CFG_BLINK_FIRST  = 2'd1,
    CFG_BLINK_SECOND = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [TickW-1:0] step_period;
    logic [TickW-1:0] blink_first_end;
    logic [TickW-1:0] blink_second_end;
  } klps_cfg_t;

endpackage

// File: hdl/klps_cfg_regs.sv
`timescale 1ns / 1ps

module klps_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [klps_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [klps_pkg::TickW-1:0]    cfg_data_i,
  output klps_pkg::klps_cfg_t           cfg_o
);
  import klps_pkg::*;

  klps_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_STEP_PERIOD:  cfg_d.step_period      = cfg_data_i;
        CFG_BLINK_FIRST:  cfg_d.blink_first_end  = cfg_data_i;
        CFG_BLINK_SECOND: cfg_d.blink_second_end = cfg_data_i;
        default:          cfg_d = cfg_q; // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_period      <= STEP_PERIOD_RST;
      cfg_q.blink_first_end  <= BLINK_FIRST_RST;
      cfg_q.blink_second_end <= BLINK_SECOND_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hdl/klps_engine.sv
`timescale 1ns / 1ps

module klps_engine (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  klps_pkg::klps_cfg_t        cfg_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [klps_pkg::KeyW-1:0]  keys_i,
  input  logic                       res_ready_i,
  output logic                       res_load_o,
  output logic [klps_pkg::LedW-1:0]  res_led_o
);
  import klps_pkg::*;

  logic             req_valid_q, req_valid_d;
  logic [KeyW-1:0]  keys_q;
  logic             armed_q, armed_d;
  logic [KeyW-1:0]  mode_q, mode_d;
  logic [TickW-1:0] tick_q, tick_d;
  logic [StepW-1:0] step_q, step_d;
  logic [LedW-1:0]  led_q, led_d;

  logic             accept;
  logic             take;
  logic             pass;
  logic [TickW-1:0] tick_inc;
  logic [StepW-1:0] step_base;
  logic             long_run;

  assign take       = req_valid_q && res_ready_i;
  assign in_stall_o = req_valid_q && !res_ready_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    if (accept) begin
      req_valid_d = 1'b1;
    end else if (take) begin
      req_valid_d = 1'b0;
    end else begin
      req_valid_d = req_valid_q;
    end
  end

  // One-shot key detect: pass a code once, re-arm when all lines are high
  assign pass = armed_q && (keys_q != NO_KEY);

  always_comb begin
    if (pass) begin
      armed_d = 1'b0;
    end else if (keys_q == NO_KEY) begin
      armed_d = 1'b1;
    end else begin
      armed_d = armed_q;
    end
  end

  assign tick_inc = tick_q + 1'b1;
  assign mode_d   = pass ? keys_q : mode_q;
  assign long_run = (mode_d == MODE_CHASE_LONG);

  always_comb begin
    led_d     = pass ? '0 : led_q;
    step_base = pass ? '0 : step_q;
    step_d    = step_base;
    tick_d    = tick_q;
    case (mode_d)
      MODE_CHASE_LONG, MODE_CHASE_SHORT: begin
        tick_d = tick_inc;
        if (tick_q == cfg_i.step_period) begin
          tick_d = '0;
          if (step_base <= FILL_LAST) begin
            led_d = {led_d[LedW-2:0], 1'b1};
          end else if (step_base <= SHIFT_LAST) begin
            led_d = {led_d[LedW-2:0], 1'b0};
          end else if (long_run && step_base <= BACK_FILL_LAST) begin
            led_d = (led_d >> 1) | LED_TOP;
          end else if (long_run && step_base <= BACK_SHIFT_LAST) begin
            led_d = led_d >> 1;
          end else begin
            step_base = '0; // idle step after the last one
          end
          step_d = step_base + 1'b1;
        end
      end
      MODE_BLINK_AA55, MODE_BLINK_0FF0: begin
        tick_d = tick_inc;
        if (tick_q <= cfg_i.blink_first_end) begin
          led_d = (mode_d == MODE_BLINK_AA55) ? LED_AA : LED_0F;
        end else if (tick_inc <= cfg_i.blink_second_end) begin
          led_d = (mode_d == MODE_BLINK_AA55) ? LED_55 : LED_F0;
        end else begin
          tick_d = '0;
        end
      end
      default: begin
        // freeze LEDs and tick counter
        tick_d = tick_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      armed_q     <= 1'b1;
      mode_q      <= '0;
      tick_q      <= '0;
      step_q      <= '0;
      led_q       <= '0;
    end else begin
      req_valid_q <= req_valid_d;
      if (take) begin
        armed_q <= armed_d;
        mode_q  <= mode_d;
        tick_q  <= tick_d;
        step_q  <= step_d;
        led_q   <= led_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      keys_q <= keys_i;
    end
  end

  assign res_load_o = take;
  assign res_led_o  = led_d;

endmodule

// File: hdl/klps_out_stage.sv
`timescale 1ns / 1ps

module klps_out_stage (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  logic [klps_pkg::LedW-1:0]  led_i,
  output logic                       ready_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [klps_pkg::LedW-1:0]  led_o
);
  import klps_pkg::*;

  logic            valid_q, valid_d;
  logic [LedW-1:0] led_q;

  // Take a new result when empty or when the held one leaves this cycle
  assign ready_o = !valid_q || !out_stall_i;

  always_comb begin
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      led_q <= led_i;
    end
  end

  assign out_valid_o = valid_q;
  assign led_o       = led_q;

endmodule

// File: hdl/keyed_led_pattern_sequencer_top.sv
`timescale 1ns / 1ps
// Channel  | Handshake               | Payload
// ---------+-------------------------+------------------------------------
// input    | in_valid_i / in_stall_o | keys_i[3:0] (active-low key lines)
// output   | out_valid_o/out_stall_i | led_o[7:0]
// config   | cfg_valid_i/cfg_ready_o | cfg_index_i[1:0], cfg_data_i[15:0]
//
// One request per clock cycle sustained while the output does not stall; each
// passes from accept to result through the input register, then the result register.
// The step logic is a single pass of 16-bit increment and compares per tick.
// Reset clears the key detector, mode, tick counter, step index and LEDs and
// loads the default periods; no clearing pass is needed.
// A stalled output holds its result; the input register then fills and
// in_stall_o rises until the output drains.

module keyed_led_pattern_sequencer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [klps_pkg::KeyW-1:0]     keys_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [klps_pkg::LedW-1:0]     led_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [klps_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [klps_pkg::TickW-1:0]    cfg_data_i
);
  import klps_pkg::*;

  klps_cfg_t       cfg;
  logic            res_ready;
  logic            res_load;
  logic [LedW-1:0] res_led;

  assign cfg_ready_o = 1'b1;

  klps_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  klps_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .keys_i      (keys_i),
    .res_ready_i (res_ready),
    .res_load_o  (res_load),
    .res_led_o   (res_led)
  );

  klps_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_load),
    .led_i       (res_led),
    .ready_o     (res_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .led_o       (led_o)
  );

endmodule

// File: hdl/klps_checker.sv
`timescale 1ns / 1ps

module klps_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [klps_pkg::LedW-1:0]     led_o,
  input logic                          cfg_ready_o
);

  // Input can only back up when the result register is full and stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while output side can take a result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty result register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(led_o)))
    else $error("stalled result dropped or changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config port not ready");

endmodule

bind keyed_led_pattern_sequencer_top klps_checker u_klps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .led_o       (led_o),
  .cfg_ready_o (cfg_ready_o)
);

// File: verif/klps_led_monitor.sv
`timescale 1ns / 1ps

module klps_led_monitor
  import klps_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [KeyW-1:0]    keys_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [LedW-1:0]    led_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [TickW-1:0]   cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  klps_cfg_t        regs;
  logic             armed;
  logic [KeyW-1:0]  mode;
  logic [TickW-1:0] ticks;
  logic [StepW-1:0] step;
  logic [LedW-1:0]  leds;
  logic [LedW-1:0]  expected_leds[$];
  int               fails = 0;

  // One loop tick: key one-shot, then the pattern of the current mode.
  function automatic logic [LedW-1:0] tick_leds(input logic [KeyW-1:0] keys);
    logic [TickW-1:0] prior;
    logic             long_run;
    if (keys != NO_KEY && armed) begin
      armed = 1'b0;
      mode  = keys;
      leds  = '0;
      step  = '0;
    end else if (keys == NO_KEY) begin
      armed = 1'b1;
    end
    prior    = ticks;
    long_run = (mode == MODE_CHASE_LONG);
    case (mode)
      MODE_CHASE_LONG, MODE_CHASE_SHORT: begin
        ticks = ticks + 1'b1;
        if (prior == regs.step_period) begin
          ticks = '0;
          if (step <= FILL_LAST) begin
            leds = {leds[LedW-2:0], 1'b1};
          end else if (step <= SHIFT_LAST) begin
            leds = {leds[LedW-2:0], 1'b0};
          end else if (long_run && step <= BACK_FILL_LAST) begin
            leds = {1'b1, leds[LedW-1:1]};
          end else if (long_run && step <= BACK_SHIFT_LAST) begin
            leds = {1'b0, leds[LedW-1:1]};
          end else begin
            // idle step past the end; the next run resumes at index 1
            step = '0;
          end
          step = step + 1'b1;
        end
      end
      MODE_BLINK_AA55, MODE_BLINK_0FF0: begin
        ticks = ticks + 1'b1;
        if (prior <= regs.blink_first_end) begin
          leds = (mode == MODE_BLINK_AA55) ? LED_AA : LED_0F;
        end else if (ticks <= regs.blink_second_end) begin
          leds = (mode == MODE_BLINK_AA55) ? LED_55 : LED_F0;
        end else begin
          ticks = '0;
        end
      end
      default: ;
    endcase
    return leds;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [LedW-1:0] want;
    if (!rst_ni) begin
      regs.step_period      = STEP_PERIOD_RST;
      regs.blink_first_end  = BLINK_FIRST_RST;
      regs.blink_second_end = BLINK_SECOND_RST;
      armed = 1'b1;
      mode  = '0;
      ticks = '0;
      step  = '0;
      leds  = '0;
      expected_leds.delete();
    end else begin
      // compare before pushing so a result can never match its own request
      if (out_valid_i && !out_stall_i) begin
        if (expected_leds.size() == 0) begin
          $error("led: unexpected result, expected none actual %02h", led_i);
          fails++;
        end else begin
          want = expected_leds.pop_front();
          if (led_i !== want) begin
            $error("led mismatch: expected %02h actual %02h", want, led_i);
            fails++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_STEP_PERIOD:  regs.step_period      = cfg_data_i;
          CFG_BLINK_FIRST:  regs.blink_first_end  = cfg_data_i;
          CFG_BLINK_SECOND: regs.blink_second_end = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        expected_leds.push_back(tick_leds(keys_i));
      end
    end
    pending_o    <= expected_leds.size();
    fail_count_o <= fails;
  end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import klps_pkg::*;

  localparam logic [CfgIdxW-1:0] CFG_SPARE  = 2'd3;
  localparam logic [KeyW-1:0]    IDLE_CODE  = 4'h0;
  localparam logic [KeyW-1:0]    STRAY_CODE = 4'h6;
  localparam int NUM_PHASES     = 7;
  localparam int SQUEEZE_AT     = 500;
  localparam int SQUEEZE_CYCLES = 80;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic [KeyW-1:0]    keys_i      = NO_KEY;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [LedW-1:0]    led_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = CFG_STEP_PERIOD;
  logic [TickW-1:0]   cfg_data_i  = '0;

  int fail_count;
  int pending;
  int n_sent     = 0;
  int burst_left = 0;
  bit squeezed   = 1'b0;

  logic [KeyW-1:0] directed [18] = '{
    NO_KEY, MODE_BLINK_AA55, MODE_BLINK_AA55, STRAY_CODE, NO_KEY,
    MODE_BLINK_0FF0, NO_KEY, MODE_CHASE_LONG, NO_KEY, MODE_CHASE_SHORT,
    NO_KEY, IDLE_CODE, NO_KEY, STRAY_CODE, STRAY_CODE, NO_KEY,
    MODE_BLINK_AA55, NO_KEY
  };

  logic [TickW-1:0] period_tab [NUM_PHASES] = '{16'd3, 16'd0, 16'd1, 16'hFFFF,
                                                16'd7, 16'd2, 16'd0};
  logic [TickW-1:0] first_tab  [NUM_PHASES] = '{16'd4, 16'd0, 16'd2, 16'hFFFF,
                                                16'd20, 16'hFFFF, 16'd0};
  logic [TickW-1:0] second_tab [NUM_PHASES] = '{16'd9, 16'd0, 16'd1, 16'hFFFF,
                                                16'd40, 16'd3, 16'd0};
  int               item_tab   [NUM_PHASES] = '{260, 300, 260, 100, 280, 260, 290};

  keyed_led_pattern_sequencer_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .keys_i      (keys_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .led_o       (led_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  klps_led_monitor u_led_monitor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .keys_i       (keys_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .led_i        (led_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [KeyW-1:0] pick_code();
    logic [KeyW-1:0] code;
    case ($urandom_range(0, 5))
      0: code = MODE_CHASE_LONG;
      1: code = MODE_CHASE_SHORT;
      2: code = MODE_BLINK_AA55;
      3: code = MODE_BLINK_0FF0;
      default: code = KeyW'($urandom_range(0, 14));
    endcase
    return code;
  endfunction

  // Keep valid high across back-to-back requests; drop it only for a gap.
  task automatic send_keys(input logic [KeyW-1:0] k);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    keys_i     <= k;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    n_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [TickW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly press, hold, release, then a run of idle ticks; the rest is noise.
  task automatic random_burst();
    logic [KeyW-1:0] code;
    logic [KeyW-1:0] other;
    int              run;
    if ($urandom_range(0, 99) < 75) begin
      code = pick_code();
      send_keys(code);
      repeat ($urandom_range(0, 3)) begin
        other = KeyW'($urandom_range(0, 14));
        send_keys(($urandom_range(0, 3) == 0) ? other : code);
      end
      send_keys(NO_KEY);
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(0, 40);
      repeat (run) send_keys(NO_KEY);
    end else begin
      repeat ($urandom_range(1, 6)) begin
        other = KeyW'($urandom_range(0, 15));
        send_keys(other);
      end
    end
  endtask

  initial begin : stimulus
    int target;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) send_keys(directed[i]);
    period_tab[6] = TickW'($urandom_range(0, 8));
    first_tab[6]  = TickW'($urandom_range(0, 30));
    second_tab[6] = TickW'($urandom_range(0, 60));
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      write_reg(CFG_STEP_PERIOD, period_tab[p]);
      write_reg(CFG_BLINK_FIRST, first_tab[p]);
      write_reg(CFG_BLINK_SECOND, second_tab[p]);
      if (p == 2 || p == 5) begin
        write_reg(CFG_SPARE, TickW'($urandom_range(0, 65535)));
      end
      target = n_sent + item_tab[p];
      while (n_sent < target) random_burst();
    end
    drain();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("keyed_led_pattern_sequencer_top regression: pass");
    end else begin
      $display("keyed_led_pattern_sequencer_top regression: fail");
    end
    $finish;
  end

  initial begin : out_stall_gen
    int r;
    @(posedge clk_i);
    forever begin
      if (!squeezed && n_sent >= SQUEEZE_AT) begin
        // hold off long enough for the block to fill and stall its input
        squeezed = 1'b1;
        out_stall_i <= 1'b1;
        repeat (SQUEEZE_CYCLES) @(posedge clk_i);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          out_stall_i <= 1'b0;
          repeat ($urandom_range(1, 12)) @(posedge clk_i);
        end else if (r < 85) begin
          out_stall_i <= 1'b1;
          repeat ($urandom_range(1, 3)) @(posedge clk_i);
        end else if (r < 95) begin
          out_stall_i <= 1'b1;
          repeat ($urandom_range(6, 25)) @(posedge clk_i);
        end else begin
          out_stall_i <= 1'b0;
          repeat ($urandom_range(20, 60)) @(posedge clk_i);
        end
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("keyed_led_pattern_sequencer_top regression: fail");
    $finish;
  end

endmodule

// File: files.f
hdl/klps_pkg.sv
hdl/klps_cfg_regs.sv
hdl/klps_engine.sv
hdl/klps_out_stage.sv
hdl/keyed_led_pattern_sequencer_top.sv
hdl/klps_checker.sv
verif/klps_led_monitor.sv
verif/tb.sv
